// ===== src/hdu_pkg.sv =====
// shared types and constants of the half-duplex 8n1 uart
// used by every module of the block; no dependencies

package hdu_pkg;

  localparam int unsigned PeriodW = 8;
  localparam int unsigned BitCntW = 4;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PhaseW  = 2;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned InW     = 16;
  localparam int unsigned OutW    = 16;

  // serial frame phases, shared by both directions
  localparam logic [PhaseW-1:0] PH_IDLE  = 2'd0;
  localparam logic [PhaseW-1:0] PH_START = 2'd1;
  localparam logic [PhaseW-1:0] PH_DATA  = 2'd2;
  localparam logic [PhaseW-1:0] PH_STOP  = 2'd3;

  localparam logic [BitCntW-1:0] DATA_BITS     = 4'd8;
  localparam logic [PeriodW-1:0] MIN_PERIOD    = 8'd2;
  localparam logic [PeriodW-1:0] PERIOD_RESET  = 8'd104;
  localparam logic [AddrW-1:0]   REG_BIT_PERIOD = 3'd0;

  typedef struct packed {
    logic was_idle;
    logic accepted;
  } tx_stat_t;

  typedef struct packed {
    logic [OutW-15:0]  pad;
    logic              rx_frame_error;
    logic [ByteW-1:0]  rx_data;
    logic              rx_valid;
    logic              rx_busy;
    logic              tx_accepted;
    logic              tx_busy;
    logic              tx_level;
  } result_t;

endpackage

// ===== src/half_duplex_uart_8n1_top.sv =====
// top level of the half-duplex 8n1 uart: input register, tx and rx units,
// result register and configuration port; depends on hdu_pkg, hdu_cfg, hdu_tx, hdu_rx
//
// usage:
//   each input item is one tick of the serial line: the sampled rx level, a send
//   request and the byte to send. each item gives exactly one result item with
//   the tx line level, busy flags, the send acknowledge and any received byte or
//   framing error of that tick.
//   an accepted item passes through the input register and then the result
//   register before its result is presented.
//   throughput: one item per clock while out_tready is high; the tx and rx state
//   updates are one pass of short logic between the input and result registers.
//   bit_period (ticks per serial bit) is written through the apb port at word 0
//   while the block is idle; values below 2 act as 2.
//   reset: both directions go idle, the rx line is taken as high, bit_period
//   returns to 104 and both channels come up empty.
//   stall: when out_tready is low the result register holds its item, the input
//   register fills and in_tready then drops; state advances only when a result
//   moves on, so no tick is lost or repeated.

module half_duplex_uart_8n1_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [0] rx_level, [1] tx_start, [9:2] tx_byte, [15:10] zero
  input  logic [hdu_pkg::InW-1:0]     in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [0] tx_level, [1] tx_busy, [2] tx_accepted, [3] rx_busy, [4] rx_valid,
  // [12:5] rx_data, [13] rx_frame_error, [15:14] zero
  output logic [hdu_pkg::OutW-1:0]    out_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hdu_pkg::AddrW-1:0]   paddr,
  input  logic [hdu_pkg::DataW-1:0]   pwdata,
  output logic [hdu_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  logic                        in_valid_r, in_valid_nxt;
  logic [hdu_pkg::InW-1:0]     in_data_r;
  logic                        out_valid_r, out_valid_nxt;
  hdu_pkg::result_t            out_data_r, res;
  logic                        adv;
  logic                        take;
  logic [hdu_pkg::PeriodW-1:0] period;
  hdu_pkg::tx_stat_t           tx_stat;
  logic                        rx_idle;

  // a buffered tick is processed when the result register is free or draining
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;
  assign take      = in_tvalid && in_tready;

  assign in_valid_nxt  = take ? 1'b1 : (adv ? 1'b0 : in_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : ((out_valid_r && out_tready) ? 1'b0 : out_valid_r);

  hdu_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .eff_period (period)
  );

  hdu_tx u_tx (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .start_req (in_data_r[1]),
    .tx_byte   (in_data_r[9:2]),
    .rx_idle   (rx_idle),
    .period    (period),
    .stat      (tx_stat),
    .tx_level  (res.tx_level),
    .tx_busy   (res.tx_busy)
  );

  assign res.tx_accepted = tx_stat.accepted;
  assign res.pad         = '0;

  hdu_rx u_rx (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .rx_level       (in_data_r[0]),
    .tx_stat        (tx_stat),
    .period         (period),
    .rx_idle        (rx_idle),
    .rx_busy        (res.rx_busy),
    .rx_valid       (res.rx_valid),
    .rx_data        (res.rx_data),
    .rx_frame_error (res.rx_frame_error)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_data_r <= in_tdata;
    end
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== src/hdu_cfg.sv =====
// configuration register file: bit_period behind an apb-style port
// depends on hdu_pkg

module hdu_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hdu_pkg::AddrW-1:0]   paddr,
  input  logic [hdu_pkg::DataW-1:0]   pwdata,
  output logic [hdu_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output logic [hdu_pkg::PeriodW-1:0] eff_period
);

  logic [hdu_pkg::PeriodW-1:0] bit_period_r;
  logic [hdu_pkg::PeriodW-1:0] bit_period_nxt;
  logic                        sel_period;

  // word index 0 only; byte offsets within the word are ignored
  assign sel_period = (paddr[hdu_pkg::AddrW-1:2] == hdu_pkg::REG_BIT_PERIOD[hdu_pkg::AddrW-1:2]);
  assign pready     = 1'b1;

  always_comb begin
    bit_period_nxt = bit_period_r;
    if (psel && penable && pwrite && pready && sel_period) begin
      bit_period_nxt = pwdata[hdu_pkg::PeriodW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= hdu_pkg::PERIOD_RESET;
    end else begin
      bit_period_r <= bit_period_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_period) begin
      prdata = {{(hdu_pkg::DataW-hdu_pkg::PeriodW){1'b0}}, bit_period_r};
    end
  end

  // periods of 0 and 1 behave as 2
  assign eff_period = (bit_period_r < hdu_pkg::MIN_PERIOD) ? hdu_pkg::MIN_PERIOD : bit_period_r;

endmodule

// ===== src/hdu_tx.sv =====
// transmit side: start bit, eight data bits lsb first, stop bit
// depends on hdu_pkg

module hdu_tx (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        start_req,
  input  logic [hdu_pkg::ByteW-1:0]   tx_byte,
  input  logic                        rx_idle,
  input  logic [hdu_pkg::PeriodW-1:0] period,
  output hdu_pkg::tx_stat_t           stat,
  output logic                        tx_level,
  output logic                        tx_busy
);

  logic [hdu_pkg::PhaseW-1:0]  phase_r, phase_nxt;
  logic [hdu_pkg::BitCntW-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [hdu_pkg::PeriodW-1:0] tick_r, tick_nxt;
  logic [hdu_pkg::ByteW-1:0]   shift_r, shift_nxt;

  logic [hdu_pkg::PhaseW-1:0]  ph_w;
  logic [hdu_pkg::BitCntW-1:0] bc_w;
  logic [hdu_pkg::PeriodW-1:0] tk_w;
  logic [hdu_pkg::ByteW-1:0]   sh_w;
  logic [hdu_pkg::PeriodW:0]   cnt;
  logic [hdu_pkg::BitCntW-1:0] bc_inc;

  always_comb begin
    stat.was_idle = (phase_r == hdu_pkg::PH_IDLE);
    stat.accepted = stat.was_idle && start_req && rx_idle;

    // a taken request loads the frame before this tick is driven
    if (stat.accepted) begin
      ph_w = hdu_pkg::PH_START;
      bc_w = '0;
      tk_w = '0;
      sh_w = tx_byte;
    end else begin
      ph_w = phase_r;
      bc_w = bit_cnt_r;
      tk_w = tick_r;
      sh_w = shift_r;
    end

    phase_nxt   = ph_w;
    bit_cnt_nxt = bc_w;
    tick_nxt    = tk_w;
    shift_nxt   = sh_w;
    tx_level    = 1'b1;
    tx_busy     = 1'b0;
    cnt         = {1'b0, tk_w} + 1'b1;
    bc_inc      = bc_w + 1'b1;

    if (ph_w != hdu_pkg::PH_IDLE) begin
      tx_busy = 1'b1;
      case (ph_w)
        hdu_pkg::PH_START: tx_level = 1'b0;
        hdu_pkg::PH_DATA:  tx_level = sh_w[0];
        default:           tx_level = 1'b1;
      endcase
      if (cnt >= {1'b0, period}) begin
        tick_nxt = '0;
        case (ph_w)
          hdu_pkg::PH_START: begin
            phase_nxt   = hdu_pkg::PH_DATA;
            bit_cnt_nxt = '0;
          end
          hdu_pkg::PH_DATA: begin
            shift_nxt   = {1'b0, sh_w[hdu_pkg::ByteW-1:1]};
            bit_cnt_nxt = bc_inc;
            if (bc_inc >= hdu_pkg::DATA_BITS) begin
              phase_nxt = hdu_pkg::PH_STOP;
            end
          end
          default: begin
            phase_nxt   = hdu_pkg::PH_IDLE;
            bit_cnt_nxt = '0;
            shift_nxt   = '0;
          end
        endcase
      end else begin
        tick_nxt = cnt[hdu_pkg::PeriodW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= hdu_pkg::PH_IDLE;
      bit_cnt_r <= '0;
      tick_r    <= '0;
      shift_r   <= '0;
    end else if (adv) begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      tick_r    <= tick_nxt;
      shift_r   <= shift_nxt;
    end
  end

endmodule

// ===== src/hdu_rx.sv =====
// receive side: falling edge detect, mid-bit sampling, stop bit check
// depends on hdu_pkg

module hdu_rx (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        rx_level,
  input  hdu_pkg::tx_stat_t           tx_stat,
  input  logic [hdu_pkg::PeriodW-1:0] period,
  output logic                        rx_idle,
  output logic                        rx_busy,
  output logic                        rx_valid,
  output logic [hdu_pkg::ByteW-1:0]   rx_data,
  output logic                        rx_frame_error
);

  logic [hdu_pkg::PhaseW-1:0]  phase_r, phase_nxt;
  logic [hdu_pkg::BitCntW-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [hdu_pkg::PeriodW-1:0] tick_r, tick_nxt;
  logic [hdu_pkg::ByteW-1:0]   shift_r, shift_nxt;
  logic                        prev_r;

  logic [hdu_pkg::PeriodW:0]   cnt;
  logic [hdu_pkg::PeriodW-1:0] limit;
  logic [hdu_pkg::BitCntW-1:0] bc_inc;

  assign rx_idle = (phase_r == hdu_pkg::PH_IDLE);

  always_comb begin
    phase_nxt      = phase_r;
    bit_cnt_nxt    = bit_cnt_r;
    tick_nxt       = tick_r;
    shift_nxt      = shift_r;
    rx_valid       = 1'b0;
    rx_frame_error = 1'b0;
    rx_data        = '0;
    cnt            = {1'b0, tick_r} + 1'b1;
    bc_inc         = bit_cnt_r + 1'b1;
    // first wait is half a bit, to land in the middle of each bit
    limit          = (phase_r == hdu_pkg::PH_START) ? {1'b0, period[hdu_pkg::PeriodW-1:1]}
                                                    : period;

    if (rx_idle) begin
      // edges are ignored while sending or when a send was just taken
      if (tx_stat.was_idle && !tx_stat.accepted && prev_r && !rx_level) begin
        phase_nxt   = hdu_pkg::PH_START;
        bit_cnt_nxt = '0;
        tick_nxt    = '0;
        shift_nxt   = '0;
      end
    end else if (cnt >= {1'b0, limit}) begin
      tick_nxt = '0;
      case (phase_r)
        hdu_pkg::PH_START: begin
          phase_nxt   = hdu_pkg::PH_DATA;
          bit_cnt_nxt = '0;
        end
        hdu_pkg::PH_DATA: begin
          shift_nxt   = {rx_level, shift_r[hdu_pkg::ByteW-1:1]};
          bit_cnt_nxt = bc_inc;
          if (bc_inc >= hdu_pkg::DATA_BITS) begin
            phase_nxt = hdu_pkg::PH_STOP;
          end
        end
        default: begin
          if (rx_level) begin
            rx_valid = 1'b1;
            rx_data  = shift_r;
          end else begin
            rx_frame_error = 1'b1;
          end
          phase_nxt   = hdu_pkg::PH_IDLE;
          bit_cnt_nxt = '0;
        end
      endcase
    end else begin
      tick_nxt = cnt[hdu_pkg::PeriodW-1:0];
    end

    rx_busy = (phase_nxt != hdu_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= hdu_pkg::PH_IDLE;
      bit_cnt_r <= '0;
      tick_r    <= '0;
      shift_r   <= '0;
      prev_r    <= 1'b1;
    end else if (adv) begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      tick_r    <= tick_nxt;
      shift_r   <= shift_nxt;
      prev_r    <= rx_level;
    end
  end

endmodule

// ===== src/hdu_chk.sv =====
// port-level checker for the half-duplex 8n1 uart, bound to the top level
// depends on hdu_pkg and half_duplex_uart_8n1_top

module hdu_chk (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [hdu_pkg::OutW-1:0] out_tdata
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // a taken send drives its start bit on the same tick
  a_tx_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1] && !out_tdata[0])
    else $error("accepted send without start bit");

  // a send is only taken with the receiver idle
  a_half_duplex: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> !out_tdata[3])
    else $error("send taken while receiving");

  a_rx_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[4] && out_tdata[13]))
    else $error("byte and framing error on one tick");

  a_rx_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[4] |-> out_tdata[12:5] == '0)
    else $error("rx data without a valid byte");

endmodule

bind half_duplex_uart_8n1_top hdu_chk u_hdu_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
